@@ hw/rtl/iea_pkg.sv @@
// Package for the indexed insert/erase array.
// Holds command and result item types, operation and status codes, and the
// control/status structs between the controller and the datapath.
package iea_pkg;

    localparam int KIND_W   = 3;
    localparam int POS_W    = 7;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam logic [KIND_W-1:0] KIND_READ       = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_INSERT     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd5;
    localparam logic [KIND_W-1:0] KIND_ERASE      = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_INDEX = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic [POS_W-1:0]         position;
        logic signed [WORD_W-1:0] value;
    } iea_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [WORD_W-1:0] read_value;
        logic [COUNT_W-1:0]       count;
    } iea_result_t;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_POS,
        RD_BELOW,
        RD_ABOVE
    } iea_rd_op_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_SHIFT,
        WR_VALUE
    } iea_wr_op_t;

    typedef struct packed {
        logic       load_item;
        logic       start;
        iea_rd_op_t rd_op;
        iea_wr_op_t wr_op;
        logic       cur_inc;
        logic       cur_dec;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       push_result;
    } iea_cmd_t;

    typedef struct packed {
        logic fault;
        logic is_read;
        logic is_ins;
        logic is_era;
        logic up_more;
        logic down_more;
    } iea_sts_t;

endpackage

@@ hw/rtl/iea_datapath.sv @@
// Datapath of the indexed insert/erase array: element memory, count,
// shift cursor, held item and result register.
// Depends on iea_pkg; driven by iea_ctrl through iea_cmd_t.
module iea_datapath #(
    parameter int CAPACITY = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  iea_pkg::iea_item_t  item_in,
    input  iea_pkg::iea_cmd_t   ctl,
    output iea_pkg::iea_sts_t   sts,
    output iea_pkg::iea_result_t result
);
    import iea_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (CW > POS_W) ? CW : POS_W;

    logic [WORD_W-1:0] mem [CAPACITY];
    logic [WORD_W-1:0] rdata_reg;

    iea_item_t           item_reg;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       cursor_reg, cursor_next;
    logic [STATUS_W-1:0] status_reg;
    logic                rd_sel_reg;
    iea_result_t         result_reg;

    logic [AW-1:0]       pos_ext, cnt_ext, cur_ext;
    logic [AW-1:0]       at_ins, at_era;
    logic [STATUS_W-1:0] status_now;
    logic [CW-1:0]       cur_below, cur_above;
    logic [IW-1:0]       rd_addr, wr_addr;
    logic [WORD_W-1:0]   wr_data;
    logic                wr_en, rd_en;
    logic                kind_read, kind_ins, kind_era;

    assign pos_ext   = AW'(item_reg.position);
    assign cnt_ext   = AW'(count_reg);
    assign cur_ext   = AW'(cursor_reg);
    assign cur_below = cursor_reg - CW'(1);
    assign cur_above = cursor_reg + CW'(1);

    assign kind_read = (item_reg.kind == KIND_READ);
    assign kind_ins  = (item_reg.kind == KIND_PUSH_FRONT) || (item_reg.kind == KIND_PUSH_BACK)
                    || (item_reg.kind == KIND_INSERT);
    assign kind_era  = (item_reg.kind == KIND_POP_FRONT) || (item_reg.kind == KIND_POP_BACK)
                    || (item_reg.kind == KIND_ERASE);

    always_comb
    begin
        case (item_reg.kind)
            KIND_PUSH_FRONT: at_ins = '0;
            KIND_PUSH_BACK:  at_ins = cnt_ext;
            default:         at_ins = pos_ext;
        endcase
        case (item_reg.kind)
            KIND_POP_FRONT: at_era = '0;
            KIND_POP_BACK:  at_era = cnt_ext - AW'(1);
            default:        at_era = pos_ext;
        endcase
    end

    always_comb
    begin
        status_now = ST_OK;
        if (kind_read || kind_era)
        begin
            if (count_reg == '0)
                status_now = ST_EMPTY;
            else if ((kind_read ? pos_ext : at_era) >= cnt_ext)
                status_now = ST_INDEX;
        end
        else if (kind_ins)
        begin
            if (at_ins > cnt_ext)
                status_now = ST_INDEX;
            else if (count_reg >= CW'(CAPACITY))
                status_now = ST_FULL;
        end
    end

    assign sts.fault     = (status_now != ST_OK);
    assign sts.is_read   = kind_read;
    assign sts.is_ins    = kind_ins;
    assign sts.is_era    = kind_era;
    assign sts.up_more   = (cur_ext > at_ins);
    assign sts.down_more = ({1'b0, cursor_reg} + (CW+1)'(1)) < {1'b0, count_reg};

    always_comb
    begin
        rd_en   = 1'b1;
        rd_addr = cur_below[IW-1:0];
        case (ctl.rd_op)
            RD_POS:   rd_addr = pos_ext[IW-1:0];
            RD_BELOW: rd_addr = cur_below[IW-1:0];
            RD_ABOVE: rd_addr = cur_above[IW-1:0];
            default:  rd_en   = 1'b0;
        endcase
    end

    assign wr_addr = cursor_reg[IW-1:0];
    assign wr_en   = (ctl.wr_op == WR_SHIFT) || (ctl.wr_op == WR_VALUE);
    assign wr_data = (ctl.wr_op == WR_VALUE) ? item_reg.value : rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.cnt_inc)
            count_next = count_reg + CW'(1);
        else if (ctl.cnt_dec)
            count_next = count_reg - CW'(1);
        cursor_next = cursor_reg;
        if (ctl.start)
            cursor_next = kind_ins ? count_reg : at_era[CW-1:0];
        else if (ctl.cur_inc)
            cursor_next = cur_above;
        else if (ctl.cur_dec)
            cursor_next = cur_below;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        cursor_reg <= cursor_next;
        if (ctl.load_item)
            item_reg <= item_in;
        if (ctl.start)
        begin
            status_reg <= status_now;
            rd_sel_reg <= kind_read && (status_now == ST_OK);
        end
        if (ctl.push_result)
        begin
            result_reg.status     <= status_reg;
            result_reg.read_value <= rd_sel_reg ? rdata_reg : '0;
            result_reg.count      <= cnt_ext[COUNT_W-1:0];
        end
    end

    assign result = result_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_value_write_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.wr_op == WR_VALUE) |-> ctl.cnt_inc && (count_reg < CW'(CAPACITY)))
        else $error("value written without room or count update");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.cnt_inc || ctl.cnt_dec) |=> !$stable(count_reg))
        else $error("count update lost");

endmodule

@@ hw/rtl/iea_ctrl.sv @@
// Controller of the indexed insert/erase array: sequences decode, element
// shifts and result hand-off, and owns both handshakes.
// Depends on iea_pkg; commands iea_datapath through iea_cmd_t.
module iea_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    input  iea_pkg::iea_sts_t  sts,
    output iea_pkg::iea_cmd_t  ctl
);
    import iea_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_UP_RD,
        S_UP_WR,
        S_DN_RD,
        S_DN_WR,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   slot_free;

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign slot_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        ctl        = '0;
        ctl.rd_op  = RD_NONE;
        ctl.wr_op  = WR_NONE;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.load_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                ctl.start = 1'b1;
                if (sts.fault)
                    state_next = S_FINISH;
                else if (sts.is_read)
                begin
                    ctl.rd_op  = RD_POS;
                    state_next = S_FINISH;
                end
                else if (sts.is_ins)
                    state_next = S_UP_RD;
                else if (sts.is_era)
                    state_next = S_DN_RD;
                else
                    state_next = S_FINISH;
            end
            S_UP_RD:
            begin
                if (sts.up_more)
                begin
                    ctl.rd_op  = RD_BELOW;
                    state_next = S_UP_WR;
                end
                else
                begin
                    ctl.wr_op   = WR_VALUE;
                    ctl.cnt_inc = 1'b1;
                    state_next  = S_FINISH;
                end
            end
            S_UP_WR:
            begin
                ctl.wr_op   = WR_SHIFT;
                ctl.cur_dec = 1'b1;
                state_next  = S_UP_RD;
            end
            S_DN_RD:
            begin
                if (sts.down_more)
                begin
                    ctl.rd_op  = RD_ABOVE;
                    state_next = S_DN_WR;
                end
                else
                begin
                    ctl.cnt_dec = 1'b1;
                    state_next  = S_FINISH;
                end
            end
            S_DN_WR:
            begin
                ctl.wr_op   = WR_SHIFT;
                ctl.cur_inc = 1'b1;
                state_next  = S_DN_RD;
            end
            S_FINISH:
            begin
                if (slot_free)
                begin
                    ctl.push_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        rsp_valid_next = rsp_valid_reg;
        if (ctl.push_result)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> cmd_stall)
        else $error("item accepted while another is in flight");

    a_fault_no_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECODE && sts.fault) |=> state_reg == S_FINISH)
        else $error("failed command entered a shift loop");

    a_push_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.push_result |-> (!rsp_valid_reg || !rsp_stall))
        else $error("result overwrote a pending item");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.push_result |=> rsp_valid && !cmd_stall)
        else $error("result push did not raise valid or release input");

endmodule

@@ hw/rtl/indexed_insert_erase_array.sv @@
// Ordered array of up to CAPACITY 32-bit words with read, push, insert, pop
// and erase by index; one result item per command item. Commands are taken
// one at a time. A read or a failed or unused command passes through decode
// and finish; a push, insert, pop or erase also loops through a read state
// and a write state for each element moved, since every move is one read
// and one write of the element memory. Elements are not cleared at reset;
// the count resets to 0.
// Depends on iea_pkg, iea_ctrl and iea_datapath.
module indexed_insert_erase_array #(
    parameter int CAPACITY = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  iea_pkg::iea_item_t   cmd,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output iea_pkg::iea_result_t rsp
);
    import iea_pkg::*;

    iea_cmd_t ctl;
    iea_sts_t sts;

    iea_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    iea_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .item_in (cmd),
        .ctl     (ctl),
        .sts     (sts),
        .result  (rsp)
    );

endmodule

@@ bench/indexed_insert_erase_array_test.sv @@
// Testbench for indexed_insert_erase_array: directed and random command items,
// a shadow copy of the array that predicts each result item, and random stalls.
// Depends on iea_pkg and the indexed_insert_erase_array RTL.
`timescale 1ns / 1ps

module indexed_insert_erase_array_test;

    import iea_pkg::*;

    localparam int DEPTH      = 64;
    localparam int QUIET_MAX  = 4000;
    localparam int HOLD_LEN   = 300;
    localparam int DRAIN_WAIT = 200;
    localparam int RANDOM_N   = 475;

    class shadow_array;
        logic [WORD_W-1:0] words [DEPTH];
        int unsigned       count;
        iea_result_t       awaited_results [$];
        int                mismatches;
        int                commands;
        int                status_seen [4];

        function new();
            count = 0;
            mismatches = 0;
            commands = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void apply_command(iea_item_t it);
            iea_result_t r;
            int unsigned at;
            r.status = ST_OK;
            r.read_value = '0;
            commands++;
            case (it.kind)
                KIND_READ:
                    if (count == 0) r.status = ST_EMPTY;
                    else if (it.position >= count) r.status = ST_INDEX;
                    else r.read_value = words[it.position];
                KIND_PUSH_FRONT, KIND_PUSH_BACK, KIND_INSERT:
                begin
                    at = (it.kind == KIND_PUSH_FRONT) ? 0
                       : (it.kind == KIND_PUSH_BACK) ? count : it.position;
                    if (at > count) r.status = ST_INDEX;
                    else if (count >= DEPTH) r.status = ST_FULL;
                    else
                    begin
                        for (int i = count; i > at; i--) words[i] = words[i-1];
                        words[at] = it.value;
                        count++;
                    end
                end
                KIND_POP_FRONT, KIND_POP_BACK, KIND_ERASE:
                begin
                    at = (it.kind == KIND_POP_FRONT) ? 0
                       : (it.kind == KIND_POP_BACK) ? ((count == 0) ? 0 : count - 1)
                       : it.position;
                    if (count == 0) r.status = ST_EMPTY;
                    else if (at >= count) r.status = ST_INDEX;
                    else
                    begin
                        for (int i = at; i + 1 < count; i++) words[i] = words[i+1];
                        count--;
                    end
                end
                default: ;
            endcase
            r.count = COUNT_W'(count);
            status_seen[r.status]++;
            awaited_results = {awaited_results, r};
        endfunction

        function void check_result(iea_result_t got);
            iea_result_t want;
            if (awaited_results.size() == 0)
            begin
                $error("result item with none awaited: status %0d count %0d",
                       got.status, got.count);
                mismatches++;
                return;
            end
            want = awaited_results[0];
            awaited_results.delete(0);
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.read_value !== want.read_value)
            begin
                $error("read_value: expected %0h, got %0h", want.read_value, got.read_value);
                mismatches++;
            end
            if (got.count !== want.count)
            begin
                $error("count: expected %0d, got %0d", want.count, got.count);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cmd_valid = 1'b0;
    logic        cmd_stall;
    iea_item_t   cmd = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    iea_result_t rsp;

    shadow_array sb;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          hold_requests = 0;
    int          hold_served = 0;
    int          hold_left = 0;
    int          quiet = 0;
    bit          filling = 1'b1;

    indexed_insert_erase_array #(.CAPACITY(DEPTH)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rsp_valid && !rsp_stall) sb.check_result(rsp);
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
        else if (++quiet >= QUIET_MAX)
        begin
            $display("indexed_insert_erase_array: mismatch");
            $finish;
        end
    end

    function automatic iea_item_t make_item(logic [KIND_W-1:0] kind, int pos,
                                            logic [WORD_W-1:0] val);
        iea_item_t it;
        it.kind = kind;
        it.position = POS_W'(pos);
        it.value = val;
        return it;
    endfunction

    task automatic send_item(iea_item_t it);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd <= it;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall !== 1'b0) @(posedge clk);
        sb.apply_command(it);
    endtask

    function automatic iea_item_t random_command();
        iea_item_t   it;
        int unsigned n;
        int unsigned pick;
        n = sb.count;
        if (n == DEPTH && $urandom_range(3) == 0) filling = 1'b0;
        else if (n == 0 && $urandom_range(1) == 0) filling = 1'b1;
        pick = $urandom_range(99);
        if (pick < 8)
            it.kind = KIND_W'($urandom);
        else if (pick < 70)
            it.kind = filling ? KIND_PUSH_FRONT + KIND_W'($urandom_range(2))
                              : KIND_POP_FRONT + KIND_W'($urandom_range(2));
        else
            it.kind = KIND_W'($urandom_range(KIND_ERASE));
        pick = $urandom_range(99);
        if (pick < 75) it.position = POS_W'($urandom_range(n));
        else if (pick < 85) it.position = POS_W'(n);
        else it.position = POS_W'($urandom);
        case ($urandom_range(19))
            0: it.value = 32'h7FFF_FFFF;
            1: it.value = 32'h8000_0000;
            2: it.value = '0;
            3: it.value = '1;
            default: it.value = $urandom;
        endcase
        return it;
    endfunction

    task automatic run_directed();
        send_item(make_item(KIND_READ, 0, 0));
        send_item(make_item(KIND_POP_FRONT, 0, 0));
        send_item(make_item(KIND_POP_BACK, 0, 0));
        send_item(make_item(KIND_ERASE, 0, 0));
        send_item(make_item(KIND_INSERT, 1, 32'h1234_5678));
        send_item(make_item(3'b111, 0, 0));
        send_item(make_item(KIND_PUSH_BACK, 0, 32'h7FFF_FFFF));
        send_item(make_item(KIND_PUSH_FRONT, 127, 32'h8000_0000));
        send_item(make_item(KIND_INSERT, 1, 32'h0000_0000));
        send_item(make_item(KIND_INSERT, 3, 32'hFFFF_FFFF));
        send_item(make_item(KIND_INSERT, 127, 32'h5555_5555));
        send_item(make_item(KIND_INSERT, 0, 32'hAAAA_AAAA));
        for (int i = 0; i < 5; i++) send_item(make_item(KIND_READ, i, 0));
        send_item(make_item(KIND_READ, 127, 0));
        send_item(make_item(KIND_ERASE, 1, 0));
        send_item(make_item(KIND_ERASE, 4, 0));
        send_item(make_item(KIND_ERASE, 127, 0));
        send_item(make_item(KIND_POP_FRONT, 0, 0));
        send_item(make_item(KIND_POP_BACK, 0, 0));
        send_item(make_item(3'b111, 127, 32'hFFFF_FFFF));
        send_item(make_item(KIND_READ, 0, 0));
    endtask

    task automatic run_random(int n_items);
        for (int i = 0; i < n_items; i++) send_item(random_command());
    endtask

    initial
    begin
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        tx_idle_pct = 14;
        rx_idle_pct = 83;
        run_directed();
        hold_requests++;
        run_random(RANDOM_N);
        tx_idle_pct = 83;
        rx_idle_pct = 14;
        run_random(RANDOM_N);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_requests++;
        run_random(RANDOM_N);
        cmd_valid <= 1'b0;
        while (sb.awaited_results.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("ran %0d command items across three stall mixes with two long output holds",
                 sb.commands);
        $display("outcomes: ok %0d, full %0d, empty %0d, bad index %0d",
                 sb.status_seen[ST_OK], sb.status_seen[ST_FULL],
                 sb.status_seen[ST_EMPTY], sb.status_seen[ST_INDEX]);
        if (sb.mismatches == 0 && sb.awaited_results.size() == 0)
            $display("indexed_insert_erase_array: match");
        else
            $display("indexed_insert_erase_array: mismatch");
        $finish;
    end

endmodule
